[rtl/core/chfp_pkg.sv]
package chfp_pkg;

   // Histogram geometry
   localparam int ALPHABET_SIZE = 128;
   localparam int COUNT_BITS    = 32;
   localparam int BIN_BITS      = $clog2(ALPHABET_SIZE);

   // Field widths of the channels
   localparam int OP_BITS     = 1;
   localparam int BYTE_BITS   = 8;
   localparam int INDEX_BITS  = 7;
   localparam int OUT_BITS    = 32;
   localparam int UNIQUE_BITS = 8;

   // The distinct-code counter stops at the top of its field.
   localparam int DISTINCT_MAX = 255;

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

   typedef logic [COUNT_BITS-1:0] count_type;
   typedef logic [BIN_BITS-1:0]   bin_type;

   localparam count_type COUNT_MAX = '1;

   // Operation codes of the input item
   localparam logic [OP_BITS-1:0] OP_ADD  = 1'b0;
   localparam logic [OP_BITS-1:0] OP_READ = 1'b1;

   // Class of a command after decoding
   typedef enum logic [1:0] {
      KIND_ADD,     // add of a byte that has a bin
      KIND_ERR,     // add of a byte beyond the alphabet
      KIND_READ,    // read of an existing bin
      KIND_EMPTY    // read of a bin beyond the alphabet
   } kind_type;

   typedef struct packed {
      kind_type kind;
      bin_type  bin;
   } cmd_type;

endpackage

[rtl/core/chfp_if.sv]
interface chfp_req_if;
   import chfp_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [OP_BITS-1:0]     operation;
   logic [BYTE_BITS-1:0]   char_byte;
   logic [INDEX_BITS-1:0]  bin_index;

   modport source (output valid, output operation, output char_byte, output bin_index,
                   input ready);
   modport sink   (input valid, input operation, input char_byte, input bin_index,
                   output ready);
endinterface

interface chfp_rsp_if;
   import chfp_pkg::*;

   logic                   valid;
   logic                   ready;
   logic                   high_byte_error;
   logic                   bin_seen;
   logic [OUT_BITS-1:0]    bin_count;
   logic [OUT_BITS-1:0]    bin_first_position;
   logic [OUT_BITS-1:0]    total_bytes;
   logic [UNIQUE_BITS-1:0] unique_chars;

   modport source (output valid, output high_byte_error, output bin_seen,
                   output bin_count, output bin_first_position, output total_bytes,
                   output unique_chars, input ready);
   modport sink   (input valid, input high_byte_error, input bin_seen,
                   input bin_count, input bin_first_position, input total_bytes,
                   input unique_chars, output ready);
endinterface

[rtl/core/char_histogram_first_position.sv]
// Channel    Direction  Fields
// req_chan   in         operation, char_byte, bin_index
// rsp_chan   out        high_byte_error, bin_seen, bin_count, bin_first_position,
//                       total_bytes, unique_chars
//
// Each item passes two back-end states: ST_FETCH reads the bin memories,
// ST_UPDATE updates the bin and loads the result register; no new item is taken
// until the last one completes, set by the single read/write port of the bin memory.
// Reset is synchronous; the seen bits clear all bins at once, no clearing pass.
// The front end keeps taking items into a four-entry queue while a result waits;
// a stalled result holds the back end, and a full queue drops req_chan.ready.
module char_histogram_first_position (
   input  logic        clock,
   input  logic        reset,
   chfp_req_if.sink    req_chan,
   chfp_rsp_if.source  rsp_chan
);
   import chfp_pkg::*;

   logic     push;
   logic     pop;
   logic     queue_full;
   logic     queue_empty;
   cmd_type  push_cmd;
   cmd_type  queue_cmd;

   // Decode items into commands.
   chfp_front u_front (
      .req_chan   (req_chan),
      .queue_full (queue_full),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   // Command queue between decode and execution.
   chfp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (queue_full),
      .pop      (pop),
      .pop_cmd  (queue_cmd),
      .empty    (queue_empty)
   );

   // Bin update and result generation.
   chfp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .queue_cmd   (queue_cmd),
      .pop         (pop),
      .rsp_chan    (rsp_chan)
   );

endmodule

[rtl/core/chfp_front.sv]
module chfp_front (
   chfp_req_if.sink           req_chan,
   input  logic               queue_full,
   output logic               push,
   output chfp_pkg::cmd_type  push_cmd
);
   import chfp_pkg::*;

   // Items are taken whenever the queue has room.
   assign req_chan.ready = !queue_full;
   assign push           = req_chan.valid && !queue_full;

   // Decode the item into a command class and a bin number.
   always_comb begin
      push_cmd.kind = KIND_EMPTY;
      push_cmd.bin  = '0;
      if (req_chan.operation == OP_ADD) begin
         if (32'(req_chan.char_byte) < ALPHABET_SIZE) begin
            push_cmd.kind = KIND_ADD;
            push_cmd.bin  = BIN_BITS'(req_chan.char_byte);
         end else begin
            push_cmd.kind = KIND_ERR;
         end
      end else if (32'(req_chan.bin_index) < ALPHABET_SIZE) begin
         push_cmd.kind = KIND_READ;
         push_cmd.bin  = BIN_BITS'(req_chan.bin_index);
      end
   end

endmodule

[rtl/core/chfp_queue.sv]
module chfp_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  chfp_pkg::cmd_type  push_cmd,
   output logic               full,
   input  logic               pop,
   output chfp_pkg::cmd_type  pop_cmd,
   output logic               empty
);
   import chfp_pkg::*;

   cmd_type                slot_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_BITS:0]     fill_ff, fill_in;

   assign full    = (fill_ff == (QPTR_BITS+1)'(QUEUE_DEPTH));
   assign empty   = (fill_ff == '0);
   assign pop_cmd = slot_ff[rd_ptr_ff];

   // Pointer and fill level update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Slot storage carries no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

[rtl/core/chfp_back.sv]
module chfp_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               queue_empty,
   input  chfp_pkg::cmd_type  queue_cmd,
   output logic               pop,
   chfp_rsp_if.source         rsp_chan
);
   import chfp_pkg::*;

   typedef enum logic [1:0] {
      ST_FETCH  = 2'b01,
      ST_UPDATE = 2'b10
   } state_type;

   state_type               state_ff, state_in;
   cmd_type                 cmd_ff;

   // Bin memories with registered read data
   count_type               count_mem [ALPHABET_SIZE];
   count_type               pos_mem   [ALPHABET_SIZE];
   count_type               cnt_rd_ff;
   count_type               pos_rd_ff;

   // One seen bit per bin; a bin that is not seen reads as a zero count.
   logic [ALPHABET_SIZE-1:0] seen_ff, seen_in;
   count_type               total_ff, total_in;
   logic [UNIQUE_BITS-1:0]  unique_ff, unique_in;

   // Result register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_error_ff;
   logic                    rsp_seen_ff;
   logic [OUT_BITS-1:0]     rsp_count_ff;
   logic [OUT_BITS-1:0]     rsp_pos_ff;
   logic [OUT_BITS-1:0]     rsp_total_ff;
   logic [UNIQUE_BITS-1:0]  rsp_unique_ff;

   logic                    fire;
   logic                    is_add;
   logic                    is_read;
   logic                    seen_cur;
   count_type               cur_count;
   count_type               cnt_next;

   assign pop  = (state_ff == ST_FETCH) && !queue_empty;
   assign fire = (state_ff == ST_UPDATE) && (!rsp_valid_ff || rsp_chan.ready);

   assign is_add    = (cmd_ff.kind == KIND_ADD);
   assign is_read   = (cmd_ff.kind == KIND_READ);
   assign seen_cur  = seen_ff[cmd_ff.bin];
   assign cur_count = seen_cur ? cnt_rd_ff : '0;
   assign cnt_next  = (cur_count == COUNT_MAX) ? cur_count : cur_count + 1'b1;

   // Sequencer: fetch the bin, then update it and post the result.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_FETCH: begin
            if (pop) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (fire) begin
               state_in = ST_FETCH;
            end
         end
         default: state_in = ST_FETCH;
      endcase
   end

   // Running totals and seen bits.
   always_comb begin
      seen_in   = seen_ff;
      total_in  = total_ff;
      unique_in = unique_ff;
      if (fire && is_add) begin
         seen_in[cmd_ff.bin] = 1'b1;
         if (!seen_cur && (unique_ff != UNIQUE_BITS'(DISTINCT_MAX))) begin
            unique_in = unique_ff + 1'b1;
         end
      end
      if (fire && (is_add || (cmd_ff.kind == KIND_ERR)) && (total_ff != COUNT_MAX)) begin
         total_in = total_ff + 1'b1;
      end
   end

   assign rsp_valid_in = fire || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FETCH;
         seen_ff      <= '0;
         total_ff     <= '0;
         unique_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seen_ff      <= seen_in;
         total_ff     <= total_in;
         unique_ff    <= unique_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Command capture and memory read on pop, memory write on update.
   always_ff @(posedge clock) begin
      if (pop) begin
         cmd_ff    <= queue_cmd;
         cnt_rd_ff <= count_mem[queue_cmd.bin];
         pos_rd_ff <= pos_mem[queue_cmd.bin];
      end
      if (fire && is_add) begin
         count_mem[cmd_ff.bin] <= cnt_next;
         if (!seen_cur) begin
            pos_mem[cmd_ff.bin] <= total_ff;
         end
      end
   end

   // Result fields, loaded as the item completes.
   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_error_ff  <= (cmd_ff.kind == KIND_ERR);
         rsp_seen_ff   <= is_read && seen_cur;
         rsp_count_ff  <= is_read ? OUT_BITS'(cur_count) : '0;
         rsp_pos_ff    <= (is_read && seen_cur) ? OUT_BITS'(pos_rd_ff) : '0;
         rsp_total_ff  <= OUT_BITS'(total_in);
         rsp_unique_ff <= unique_in;
      end
   end

   assign rsp_chan.valid              = rsp_valid_ff;
   assign rsp_chan.high_byte_error    = rsp_error_ff;
   assign rsp_chan.bin_seen           = rsp_seen_ff;
   assign rsp_chan.bin_count          = rsp_count_ff;
   assign rsp_chan.bin_first_position = rsp_pos_ff;
   assign rsp_chan.total_bytes        = rsp_total_ff;
   assign rsp_chan.unique_chars       = rsp_unique_ff;

endmodule
